FILE: sv/bbsf_pkg.sv
// Shared constants, types and helpers for the binary sensor fusion core.
package bbsf_pkg;

  localparam int NUM_INPUTS = 9;
  localparam int PCT_W      = 7;
  localparam int IDX_W      = 4;
  localparam int TABLE_W    = NUM_INPUTS * PCT_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = TABLE_W;

  // 100^9 fits in 60 bits, 100^10 in 67 bits, 100^11 in 74 bits.
  localparam int PROD_W = 60;
  localparam int NUM_W  = 67;
  localparam int REM_W  = 74;

  // The quotient never exceeds 100, so seven restoring steps are enough.
  localparam int DIV_STEPS = PCT_W;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  localparam logic [CFG_ADDR_W-1:0] REG_PRIOR     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_P_TRUE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_P_FALSE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PROB_OUT  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_CHANGE = 3'd6;

  localparam logic REQ_TELEGRAM = 1'b0;
  localparam logic REQ_INIT     = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic             take;      // input transfer this cycle
    logic             mul_en;    // fold one lane into both products
    logic [IDX_W-1:0] lane;      // lane being folded
    logic             scale_en;  // weight products by the prior
    logic             sum_en;    // form denominator and scaled numerator
    logic             div_en;    // one restoring division step
    logic             load_out;  // finish the item and fill the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic calc;      // the offered item produces a result
    logic out_free;  // output register can take a result this cycle
  } stat_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

endpackage

FILE: sv/bbsf_ctrl.sv
// Sequencing state machine for the fusion core.
module bbsf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  bbsf_pkg::stat_t stat,
  output bbsf_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_SUM,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [bbsf_pkg::IDX_W-1:0] LANE_LAST =
    bbsf_pkg::IDX_W'(bbsf_pkg::NUM_INPUTS - 1);
  localparam logic [bbsf_pkg::IDX_W-1:0] DIV_LAST =
    bbsf_pkg::IDX_W'(bbsf_pkg::DIV_STEPS - 1);

  state_t                       state_r, state_nxt;
  logic [bbsf_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid && stat.calc) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LANE_LAST) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.take     = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_en   = (state_r == S_MUL);
    cmd.lane     = cnt_r;
    cmd.scale_en = (state_r == S_SCALE);
    cmd.sum_en   = (state_r == S_SUM);
    cmd.div_en   = (state_r == S_DIV);
    cmd.load_out = (state_r == S_FIN) && stat.out_free;
  end

endmodule

FILE: sv/bbsf_dp.sv
// Datapath: settings, sensor state, likelihood products, divider and output register.
module bbsf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbsf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bbsf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_req_type,
  input  logic [bbsf_pkg::IDX_W-1:0]        in_index,
  input  logic                              in_value,
  input  bbsf_pkg::cmd_t                    cmd,
  output bbsf_pkg::stat_t                   stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata
);

  localparam int N  = bbsf_pkg::NUM_INPUTS;
  localparam int PW = bbsf_pkg::PCT_W;

  // Settings.
  logic [PW-1:0]                prior_r, thresh_r;
  logic [N-1:0]                 enable_r;
  logic [bbsf_pkg::TABLE_W-1:0] p_true_r, p_false_r;
  logic                         prob_out_r, on_change_r;

  // Sensor state and send history.
  logic [N-1:0]  values_r, seen_r;
  logic [PW-1:0] last_prob_r;
  logic          last_bin_r;

  // Arithmetic.
  logic [bbsf_pkg::PROD_W-1:0] pt_r, pf_r;
  logic [bbsf_pkg::NUM_W-1:0]  num_r, pfw_r, den_r;
  logic [bbsf_pkg::REM_W-1:0]  rem_r, dsh_r;
  logic [PW-1:0]               q_r;

  // Output register.
  logic          out_valid_r;
  logic          o_psend_r, o_bsend_r, o_bin_r;
  logic [PW-1:0] o_prob_r;

  logic [bbsf_pkg::IDX_W-1:0] active_cnt;
  logic                       idx_active;
  logic [PW-1:0]              prior_sat;
  logic [PW-1:0]              lane_t [N];
  logic [PW-1:0]              lane_f [N];
  logic                       lane_use;
  logic [PW-1:0]              fac_t, fac_f;
  logic                       div_ge;
  logic [PW-1:0]              post;
  logic                       bin;
  logic                       psend, bsend;

  assign active_cnt = bbsf_pkg::IDX_W'(N) - bbsf_pkg::IDX_W'(prob_out_r);
  assign idx_active = (in_index < active_cnt);
  assign prior_sat  = bbsf_pkg::sat_pct(prior_r);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lane_t[i] = bbsf_pkg::sat_pct(p_true_r[i*PW +: PW]);
      lane_f[i] = bbsf_pkg::sat_pct(p_false_r[i*PW +: PW]);
    end
  end

  // A lane counts when it is enabled, active and holds a value.
  assign lane_use = (cmd.lane < active_cnt) && enable_r[cmd.lane] && seen_r[cmd.lane];
  assign fac_t    = values_r[cmd.lane] ? lane_t[cmd.lane]
                                       : bbsf_pkg::PCT_FULL - lane_t[cmd.lane];
  assign fac_f    = values_r[cmd.lane] ? lane_f[cmd.lane]
                                       : bbsf_pkg::PCT_FULL - lane_f[cmd.lane];

  assign div_ge = (dsh_r <= rem_r);
  assign post   = (den_r == '0) ? prior_sat : q_r;
  assign bin    = (post >= thresh_r);
  assign psend  = prob_out_r && (!on_change_r || (post != last_prob_r));
  assign bsend  = !on_change_r || (bin != last_bin_r);

  assign stat.calc     = (in_req_type == bbsf_pkg::REQ_TELEGRAM) && idx_active;
  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r     <= PW'(50);
      thresh_r    <= PW'(50);
      enable_r    <= '0;
      p_true_r    <= '0;
      p_false_r   <= '0;
      prob_out_r  <= 1'b0;
      on_change_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bbsf_pkg::REG_PRIOR:     prior_r     <= cfg_wdata[PW-1:0];
        bbsf_pkg::REG_THRESHOLD: thresh_r    <= cfg_wdata[PW-1:0];
        bbsf_pkg::REG_ENABLE:    enable_r    <= cfg_wdata[N-1:0];
        bbsf_pkg::REG_P_TRUE:    p_true_r    <= cfg_wdata;
        bbsf_pkg::REG_P_FALSE:   p_false_r   <= cfg_wdata;
        bbsf_pkg::REG_PROB_OUT:  prob_out_r  <= cfg_wdata[0];
        bbsf_pkg::REG_ON_CHANGE: on_change_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      values_r    <= '0;
      seen_r      <= '0;
      last_prob_r <= '0;
      last_bin_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (in_req_type == bbsf_pkg::REQ_INIT) begin
          // Enabled inputs without a value are forced to false.
          values_r <= values_r & ~(enable_r & ~seen_r);
          seen_r   <= seen_r | enable_r;
        end else if (idx_active) begin
          values_r[in_index] <= in_value;
          seen_r[in_index]   <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (psend) begin
          last_prob_r <= post;
        end
        if (bsend) begin
          last_bin_r <= bin;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pt_r <= bbsf_pkg::PROD_W'(1);
      pf_r <= bbsf_pkg::PROD_W'(1);
    end else if (cmd.mul_en && lane_use) begin
      pt_r <= pt_r * bbsf_pkg::PROD_W'(fac_t);
      pf_r <= pf_r * bbsf_pkg::PROD_W'(fac_f);
    end
    if (cmd.scale_en) begin
      num_r <= bbsf_pkg::NUM_W'(pt_r) * bbsf_pkg::NUM_W'(prior_sat);
      pfw_r <= bbsf_pkg::NUM_W'(pf_r) * bbsf_pkg::NUM_W'(bbsf_pkg::PCT_FULL - prior_sat);
    end
    if (cmd.sum_en) begin
      den_r <= num_r + pfw_r;
      rem_r <= bbsf_pkg::REM_W'(num_r) * bbsf_pkg::REM_W'(bbsf_pkg::PCT_FULL);
      dsh_r <= bbsf_pkg::REM_W'(num_r + pfw_r) << (bbsf_pkg::DIV_STEPS - 1);
      q_r   <= '0;
    end else if (cmd.div_en) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[PW-2:0], div_ge};
    end
    if (cmd.load_out) begin
      o_psend_r <= psend;
      o_prob_r  <= post;
      o_bsend_r <= bsend;
      o_bin_r   <= bin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_bin_r, o_bsend_r, o_prob_r, o_psend_r};

endmodule

FILE: sv/bayesian_binary_sensor_fusion_core.sv
// Top level of the naive Bayes binary sensor fusion core.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid / tready    tuser: req_type; tdata: input_index, input_value
//   out_     master     tvalid / tready    tdata: prob_send, prob_percent, binary_send,
//                                          binary_state
//   cfg_     write      cfg_we             cfg_addr selects, cfg_wdata carries the value
//
// A telegram on an active input is taken, folded through the shared product multipliers
// one lane at a time for all nine lanes, weighted by the prior, summed into the
// denominator, divided in seven restoring steps and finished into the output register.
// Init requests and telegrams on inactive inputs complete in their transfer cycle.
// Reset is synchronous and clears state and settings to their defaults.
// A result waits in the output register; the next item is taken meanwhile, and a later
// result holds in its final step until the register frees.
module bayesian_binary_sensor_fusion_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bbsf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bbsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // input_index[3:0], input_value[4]
  input  logic                            in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata   // prob_send[0], prob_percent[7:1],
                                                      // binary_send[8], binary_state[9]
);

  bbsf_pkg::cmd_t  cmd;
  bbsf_pkg::stat_t stat;

  bbsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbsf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_req_type (in_tuser),
    .in_index    (in_tdata[3:0]),
    .in_value    (in_tdata[4]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

FILE: verif/tb_bayesian_binary_sensor_fusion_core.sv
// Self-checking testbench for the naive Bayes binary sensor fusion core.
`timescale 1ns / 1ps

module tb_bayesian_binary_sensor_fusion_core;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 25;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic                       prob_send;
    logic [bbsf_pkg::PCT_W-1:0] prob_pct;
    logic                       binary_send;
    logic                       binary_state;
  } fusion_result_t;

  typedef struct {
    logic                            is_cfg;
    logic [bbsf_pkg::CFG_ADDR_W-1:0] addr;
    logic [bbsf_pkg::CFG_DATA_W-1:0] wdata;
    logic                            req;
    logic [bbsf_pkg::IDX_W-1:0]      idx;
    logic                            val;
    logic                            fixed;
    fusion_result_t                  known;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [bbsf_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [bbsf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = '0;   // input_index[3:0], input_value[4]
  logic                            in_tuser = 1'b0; // req_type
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;       // prob_send[0], prob_percent[7:1],
                                                    // binary_send[8], binary_state[9]

  // Shadow copy of the settings and the sensor state.
  logic [bbsf_pkg::PCT_W-1:0]      m_prior = 7'd50;
  logic [bbsf_pkg::PCT_W-1:0]      m_thresh = 7'd50;
  logic [bbsf_pkg::NUM_INPUTS-1:0] m_mask = '0;
  logic [bbsf_pkg::TABLE_W-1:0]    m_ptrue = '0;
  logic [bbsf_pkg::TABLE_W-1:0]    m_pfalse = '0;
  logic                            m_prob_out = 1'b0;
  logic                            m_on_change = 1'b0;
  logic [bbsf_pkg::NUM_INPUTS-1:0] sensor_val = '0;
  logic [bbsf_pkg::NUM_INPUTS-1:0] sensor_seen = '0;
  logic [bbsf_pkg::PCT_W-1:0]      last_prob = '0;
  logic                            last_bin = 1'b0;

  fusion_result_t pending_posteriors[$];
  stim_row_t      directed_rows[$];
  fusion_result_t got, want;

  int  errors = 0;
  int  items_sent = 0;
  int  items_ignored = 0;
  int  results_checked = 0;
  int  settings_written = 0;
  int  stall_cycles = 0;
  logic quiet = 1'b0;

  bayesian_binary_sensor_fusion_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got_v, exp_v);
    errors++;
  endtask

  // Exact posterior in percent: floor(100 * num / den), at most 100.
  function automatic logic [bbsf_pkg::PCT_W-1:0] fused_posterior();
    logic [127:0]               pt, pf, num, den, q;
    logic [bbsf_pkg::PCT_W-1:0] prior, t, f;
    int                         active, i;
    prior = (m_prior > bbsf_pkg::PCT_W'(100)) ? bbsf_pkg::PCT_W'(100) : m_prior;
    active = bbsf_pkg::NUM_INPUTS - int'(m_prob_out);
    pt = 128'd1;
    pf = 128'd1;
    for (i = 0; i < active; i++) begin
      if (m_mask[i] && sensor_seen[i]) begin
        t = m_ptrue[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W];
        f = m_pfalse[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W];
        if (t > bbsf_pkg::PCT_W'(100)) t = bbsf_pkg::PCT_W'(100);
        if (f > bbsf_pkg::PCT_W'(100)) f = bbsf_pkg::PCT_W'(100);
        if (sensor_val[i]) begin
          pt = pt * t;
          pf = pf * f;
        end else begin
          pt = pt * (100 - t);
          pf = pf * (100 - f);
        end
      end
    end
    num = pt * prior;
    den = pf * (100 - prior) + num;
    if (den == 0) return prior;
    q = (num * 100) / den;
    if (q > 100) q = 100;
    return q[bbsf_pkg::PCT_W-1:0];
  endfunction

  task automatic predict_fusion(input logic req, input logic [bbsf_pkg::IDX_W-1:0] idx,
                                input logic val, output logic has,
                                output fusion_result_t r);
    logic [bbsf_pkg::PCT_W-1:0] p;
    logic                       b;
    int                         i;
    has = 1'b0;
    r = '0;
    if (req == bbsf_pkg::REQ_INIT) begin
      for (i = 0; i < bbsf_pkg::NUM_INPUTS; i++) begin
        if (m_mask[i] && !sensor_seen[i]) begin
          sensor_val[i] = 1'b0;
          sensor_seen[i] = 1'b1;
        end
      end
      return;
    end
    if (int'(idx) >= bbsf_pkg::NUM_INPUTS - int'(m_prob_out)) return;
    sensor_val[idx] = val;
    sensor_seen[idx] = 1'b1;
    p = fused_posterior();
    b = (p >= m_thresh);
    r.prob_pct = p;
    r.binary_state = b;
    if (m_prob_out && (!m_on_change || p != last_prob)) begin
      r.prob_send = 1'b1;
      last_prob = p;
    end
    if (!m_on_change || b != last_bin) begin
      r.binary_send = 1'b1;
      last_bin = b;
    end
    has = 1'b1;
  endtask

  task automatic write_reg(input logic [bbsf_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [bbsf_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      bbsf_pkg::REG_PRIOR:     m_prior = data[bbsf_pkg::PCT_W-1:0];
      bbsf_pkg::REG_THRESHOLD: m_thresh = data[bbsf_pkg::PCT_W-1:0];
      bbsf_pkg::REG_ENABLE:    m_mask = data[bbsf_pkg::NUM_INPUTS-1:0];
      bbsf_pkg::REG_P_TRUE:    m_ptrue = data[bbsf_pkg::TABLE_W-1:0];
      bbsf_pkg::REG_P_FALSE:   m_pfalse = data[bbsf_pkg::TABLE_W-1:0];
      bbsf_pkg::REG_PROB_OUT:  m_prob_out = data[0];
      bbsf_pkg::REG_ON_CHANGE: m_on_change = data[0];
      default: ;
    endcase
    settings_written++;
    @(posedge clk);
  endtask

  // Waits until every result is in, then lets the core finish any silent item.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_posteriors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic req, input logic [bbsf_pkg::IDX_W-1:0] idx,
                           input logic val, input logic fixed, input fusion_result_t known,
                           output logic effective);
    fusion_result_t r;
    logic           has;
    while (!quiet && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {3'b000, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_fusion(req, idx, val, has, r);
    if (has) pending_posteriors.push_back(fixed ? known : r);
    effective = has || (req == bbsf_pkg::REQ_INIT);
    items_sent++;
    if (!effective) items_ignored++;
  endtask

  task automatic add_write(input logic [bbsf_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [bbsf_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr = addr;
    row.wdata = data;
    directed_rows.push_back(row);
  endtask

  task automatic add_item(input logic req, input logic [bbsf_pkg::IDX_W-1:0] idx,
                          input logic val);
    stim_row_t row;
    row = '{default: '0};
    row.req = req;
    row.idx = idx;
    row.val = val;
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input logic [bbsf_pkg::IDX_W-1:0] idx, input logic val,
                           input logic ps, input logic [bbsf_pkg::PCT_W-1:0] p,
                           input logic bs, input logic b);
    stim_row_t row;
    row = '{default: '0};
    row.req = bbsf_pkg::REQ_TELEGRAM;
    row.idx = idx;
    row.val = val;
    row.fixed = 1'b1;
    row.known = '{prob_send: ps, prob_pct: p, binary_send: bs, binary_state: b};
    directed_rows.push_back(row);
  endtask

  function automatic logic [bbsf_pkg::PCT_W-1:0] random_pct();
    case ($urandom_range(0, 7))
      0:       return bbsf_pkg::PCT_W'(0);
      1:       return bbsf_pkg::PCT_W'(100);
      2:       return bbsf_pkg::PCT_W'($urandom_range(101, 127));
      default: return bbsf_pkg::PCT_W'($urandom_range(0, 100));
    endcase
  endfunction

  // Likelihood lanes lean to the open interval so that products rarely collapse.
  function automatic logic [bbsf_pkg::TABLE_W-1:0] random_table();
    logic [bbsf_pkg::TABLE_W-1:0] tbl;
    int                           i;
    for (i = 0; i < bbsf_pkg::NUM_INPUTS; i++) begin
      case ($urandom_range(0, 9))
        0:       tbl[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W] = bbsf_pkg::PCT_W'(0);
        1:       tbl[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W] = bbsf_pkg::PCT_W'(100);
        2:       tbl[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W] =
                   bbsf_pkg::PCT_W'($urandom_range(101, 127));
        default: tbl[bbsf_pkg::PCT_W*i +: bbsf_pkg::PCT_W] =
                   bbsf_pkg::PCT_W'($urandom_range(1, 99));
      endcase
    end
    return tbl;
  endfunction

  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 21);
  end

  // Result checker: each output transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.prob_send = out_tdata[0];
      got.prob_pct = out_tdata[7:1];
      got.binary_send = out_tdata[8];
      got.binary_state = out_tdata[9];
      if (pending_posteriors.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", out_tdata, 0);
      end else begin
        want = pending_posteriors.pop_front();
        if (got.prob_send !== want.prob_send)
          report_mismatch("prob_send", got.prob_send, want.prob_send);
        if (got.prob_pct !== want.prob_pct)
          report_mismatch("prob_percent", got.prob_pct, want.prob_pct);
        if (got.binary_send !== want.binary_send)
          report_mismatch("binary_send", got.binary_send, want.binary_send);
        if (got.binary_state !== want.binary_state)
          report_mismatch("binary_state", got.binary_state, want.binary_state);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int        phase, counted, n;
    logic      eff;
    stim_row_t row;

    // Settings are at their defaults here: prior 50, threshold 50, nothing enabled.
    add_known(4'd0, 1'b1, 1'b0, 7'd50, 1'b1, 1'b1);
    add_known(4'd8, 1'b0, 1'b0, 7'd50, 1'b1, 1'b1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd9, 1'b1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd15, 1'b0);
    add_item(bbsf_pkg::REQ_INIT, 4'd0, 1'b0);
    add_write(bbsf_pkg::REG_PROB_OUT, 63'd1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd8, 1'b1);
    add_known(4'd7, 1'b1, 1'b1, 7'd50, 1'b1, 1'b1);
    add_write(bbsf_pkg::REG_PRIOR, 63'd0);
    add_known(4'd0, 1'b0, 1'b1, 7'd0, 1'b1, 1'b0);
    add_write(bbsf_pkg::REG_PRIOR, 63'd100);
    add_known(4'd1, 1'b1, 1'b1, 7'd100, 1'b1, 1'b1);
    // A prior above hundred saturates.
    add_write(bbsf_pkg::REG_PRIOR, 63'd127);
    add_known(4'd2, 1'b0, 1'b1, 7'd100, 1'b1, 1'b1);
    // A threshold above hundred can never be reached.
    add_write(bbsf_pkg::REG_THRESHOLD, 63'd127);
    add_known(4'd3, 1'b1, 1'b1, 7'd100, 1'b1, 1'b0);
    // Zero true likelihood against a certain prior leaves a zero denominator.
    add_write(bbsf_pkg::REG_THRESHOLD, 63'd0);
    add_write(bbsf_pkg::REG_PRIOR, 63'd100);
    add_write(bbsf_pkg::REG_ENABLE, 63'd1);
    add_known(4'd0, 1'b1, 1'b1, 7'd100, 1'b1, 1'b1);
    // All true lanes at 127 must count as 100.
    add_write(bbsf_pkg::REG_P_TRUE, {bbsf_pkg::TABLE_W{1'b1}});
    add_write(bbsf_pkg::REG_P_FALSE, {bbsf_pkg::NUM_INPUTS{7'd30}});
    add_write(bbsf_pkg::REG_PRIOR, 63'd50);
    add_write(bbsf_pkg::REG_THRESHOLD, 63'd50);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd0, 1'b1);
    add_write(bbsf_pkg::REG_ENABLE, 63'h1ff);
    add_item(bbsf_pkg::REQ_INIT, 4'd0, 1'b0);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd4, 1'b1);
    add_write(bbsf_pkg::REG_ON_CHANGE, 63'd1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd4, 1'b1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd4, 1'b1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd5, 1'b0);
    add_write(bbsf_pkg::REG_PROB_OUT, 63'd0);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd8, 1'b1);
    add_item(bbsf_pkg::REQ_TELEGRAM, 4'd8, 1'b1);
    add_write(bbsf_pkg::REG_ON_CHANGE, 63'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.addr, row.wdata);
      end else begin
        send_item(row.req, row.idx, row.val, row.fixed, row.known, eff);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      quiet = (phase == 3);
      write_reg(bbsf_pkg::REG_PRIOR, bbsf_pkg::CFG_DATA_W'(random_pct()));
      write_reg(bbsf_pkg::REG_THRESHOLD, bbsf_pkg::CFG_DATA_W'(random_pct()));
      write_reg(bbsf_pkg::REG_ENABLE,
                ($urandom_range(0, 3) == 0) ? bbsf_pkg::CFG_DATA_W'(9'h1ff)
                                            : bbsf_pkg::CFG_DATA_W'(9'($urandom())));
      write_reg(bbsf_pkg::REG_P_TRUE, random_table());
      write_reg(bbsf_pkg::REG_P_FALSE, random_table());
      write_reg(bbsf_pkg::REG_PROB_OUT, bbsf_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(bbsf_pkg::REG_ON_CHANGE, bbsf_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (phase == 6 && counted == ITEMS_PER_PHASE / 2) begin
          // Hold the sender back until the core has emptied out.
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_posteriors.size() != 0);
        end
        n = $urandom_range(0, 99);
        if (n < 5)
          send_item(bbsf_pkg::REQ_INIT, bbsf_pkg::IDX_W'($urandom()), 1'($urandom()),
                    1'b0, '0, eff);
        else if (n < 11)
          send_item(bbsf_pkg::REQ_TELEGRAM, bbsf_pkg::IDX_W'($urandom_range(9, 15)),
                    1'($urandom()), 1'b0, '0, eff);
        else
          send_item(bbsf_pkg::REQ_TELEGRAM,
                    bbsf_pkg::IDX_W'($urandom_range(0, bbsf_pkg::NUM_INPUTS - 1)),
                    1'($urandom()), 1'b0, '0, eff);
        if (eff) counted++;
      end
    end

    quiet = 1'b0;
    in_tvalid <= 1'b0;
    for (n = 0; n < 2000 && pending_posteriors.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_posteriors.size() != 0)
      report_mismatch("results still outstanding", pending_posteriors.size(), 0);

    $display("Sent %0d input transfers (%0d ignored) over %0d register writes,",
             items_sent, items_ignored, settings_written);
    $display("and checked %0d fusion results with %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: bayesian_binary_sensor_fusion_core.f
sv/bbsf_pkg.sv
sv/bbsf_ctrl.sv
sv/bbsf_dp.sv
sv/bayesian_binary_sensor_fusion_core.sv
verif/tb_bayesian_binary_sensor_fusion_core.sv
